[hdl/sbpr_pkg.sv]
`timescale 1ns / 1ps
// shared types, constants and crc function for the servo bus packet receiver
package sbpr_pkg;

	localparam logic [7:0]  HDR_A    = 8'hFF;
	localparam logic [7:0]  HDR_B    = 8'hFF;
	localparam logic [7:0]  HDR_C    = 8'hFD;
	localparam logic [7:0]  HDR_D    = 8'h00;
	localparam logic [15:0] CRC_POLY = 16'h8005;
	localparam logic [15:0] HDR_LEN  = 16'd4;

	localparam logic CMD_RX_BYTE = 1'b0;
	localparam logic CMD_TX_SENT = 1'b1;

	localparam logic KIND_PARAM   = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	typedef enum logic [3:0] {
		PH_H0    = 4'd0,
		PH_H1    = 4'd1,
		PH_H2    = 4'd2,
		PH_H3    = 4'd3,
		PH_ID    = 4'd4,
		PH_L0    = 4'd5,
		PH_L1    = 4'd6,
		PH_INS   = 4'd7,
		PH_ERR   = 4'd8,
		PH_PARAM = 4'd9,
		PH_CRC0  = 4'd10,
		PH_CRC1  = 4'd11
	} phase_t;

	typedef struct packed {
		logic        command;
		logic [7:0]  byte_value;
		logic [15:0] sent_count;
	} item_t;

	typedef struct packed {
		logic        kind;
		logic [7:0]  param_byte;
		logic [15:0] param_position;
		logic [7:0]  packet_id;
		logic [7:0]  instruction_code;
		logic [7:0]  error_code;
		logic        crc_ok;
		logic        last;
	} result_t;

	// crc-16, msb first, not reflected, no final xor
	function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
		end
		return c;
	endfunction

endpackage

[hdl/sbpr_in_stage.sv]
`timescale 1ns / 1ps
// input register stage holding one bus event request
module sbpr_in_stage (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  sbpr_pkg::item_t in_item,
	input  logic          advance,
	output logic          item_valid,
	output sbpr_pkg::item_t item
);
	import sbpr_pkg::*;

	logic  valid_s1;
	item_t item_s1;

	// take a new request when empty or when the held one moves on this cycle
	assign in_stall   = valid_s1 && !advance;
	assign item_valid = valid_s1;
	assign item       = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_item;
		end
	end

endmodule

[hdl/sbpr_parser.sv]
`timescale 1ns / 1ps
// packet parser state and per-byte next-state logic
module sbpr_parser (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  sbpr_pkg::item_t   item,
	output logic              res_valid,
	output sbpr_pkg::result_t res
);
	import sbpr_pkg::*;

	phase_t      phase_q, phase_d;
	logic [15:0] echo_q, echo_d;
	logic [7:0]  id_q, id_d;
	logic [15:0] len_q, len_d;
	logic [15:0] pidx_q, pidx_d;
	logic [7:0]  ins_q, ins_d;
	logic [7:0]  err_q, err_d;
	logic [15:0] crc_q, crc_d;
	logic [7:0]  crc_lo_q, crc_lo_d;

	logic [16:0] echo_sum;
	logic [15:0] crc_next;
	logic [15:0] len_full;
	logic [15:0] param_count;
	logic [15:0] pidx_inc;
	logic [7:0]  b;

	assign b           = item.byte_value;
	assign echo_sum    = {1'b0, echo_q} + {1'b0, item.sent_count};
	assign crc_next    = crc_fold(crc_q, b);
	assign len_full    = {b, len_q[7:0]};
	assign param_count = len_q - HDR_LEN;
	assign pidx_inc    = pidx_q + 16'd1;

	always_comb begin
		phase_d   = phase_q;
		echo_d    = echo_q;
		id_d      = id_q;
		len_d     = len_q;
		pidx_d    = pidx_q;
		ins_d     = ins_q;
		err_d     = err_q;
		crc_d     = crc_q;
		crc_lo_d  = crc_lo_q;

		if (item.command == CMD_TX_SENT) begin
			// echo count saturates
			echo_d = echo_sum[16] ? 16'hFFFF : echo_sum[15:0];
		end else if (echo_q != 16'd0) begin
			echo_d = echo_q - 16'd1;
		end else begin
			unique case (phase_q)
				PH_H0: begin
					crc_d   = (b == HDR_A) ? crc_fold(16'd0, b) : 16'd0;
					phase_d = (b == HDR_A) ? PH_H1 : PH_H0;
				end
				PH_H1: begin
					if (b == HDR_B) begin
						crc_d   = crc_next;
						phase_d = PH_H2;
					end else begin
						phase_d = PH_H0;
					end
				end
				PH_H2: begin
					if (b == HDR_C) begin
						crc_d   = crc_next;
						phase_d = PH_H3;
					end else begin
						phase_d = PH_H0;
					end
				end
				PH_H3: begin
					if (b == HDR_D) begin
						crc_d   = crc_next;
						phase_d = PH_ID;
					end else begin
						phase_d = PH_H0;
					end
				end
				PH_ID: begin
					id_d    = b;
					crc_d   = crc_next;
					phase_d = PH_L0;
				end
				PH_L0: begin
					len_d   = {8'h00, b};
					crc_d   = crc_next;
					phase_d = PH_L1;
				end
				PH_L1: begin
					len_d   = len_full;
					crc_d   = crc_next;
					pidx_d  = 16'd0;
					phase_d = (len_full < HDR_LEN) ? PH_H0 : PH_INS;
				end
				PH_INS: begin
					ins_d   = b;
					crc_d   = crc_next;
					phase_d = PH_ERR;
				end
				PH_ERR: begin
					err_d   = b;
					crc_d   = crc_next;
					phase_d = (len_q == HDR_LEN) ? PH_CRC0 : PH_PARAM;
				end
				PH_PARAM: begin
					crc_d  = crc_next;
					pidx_d = pidx_inc;
					if (pidx_inc == param_count) begin
						phase_d = PH_CRC0;
					end
				end
				PH_CRC0: begin
					crc_lo_d = b;
					phase_d  = PH_CRC1;
				end
				PH_CRC1: begin
					phase_d = PH_H0;
				end
				default: begin
					phase_d = PH_H0;
				end
			endcase
		end
	end

	always_comb begin
		res_valid = 1'b0;
		res.kind             = KIND_PARAM;
		res.param_byte       = b;
		res.param_position   = pidx_q;
		res.packet_id        = id_q;
		res.instruction_code = ins_q;
		res.error_code       = err_q;
		res.crc_ok           = 1'b0;
		res.last             = 1'b0;

		if (item.command == CMD_RX_BYTE && echo_q == 16'd0) begin
			unique case (phase_q)
				PH_PARAM: begin
					res_valid = 1'b1;
				end
				PH_CRC1: begin
					res_valid          = 1'b1;
					res.kind           = KIND_SUMMARY;
					res.param_byte     = 8'h00;
					res.param_position = param_count;
					res.crc_ok         = ({b, crc_lo_q} == crc_q);
					res.last           = 1'b1;
				end
				default: begin
					res_valid = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_H0;
			echo_q   <= 16'd0;
			id_q     <= 8'd0;
			len_q    <= 16'd0;
			pidx_q   <= 16'd0;
			ins_q    <= 8'd0;
			err_q    <= 8'd0;
			crc_q    <= 16'd0;
			crc_lo_q <= 8'd0;
		end else if (fire) begin
			phase_q  <= phase_d;
			echo_q   <= echo_d;
			id_q     <= id_d;
			len_q    <= len_d;
			pidx_q   <= pidx_d;
			ins_q    <= ins_d;
			err_q    <= err_d;
			crc_q    <= crc_d;
			crc_lo_q <= crc_lo_d;
		end
	end

endmodule

[hdl/sbpr_out_stage.sv]
`timescale 1ns / 1ps
// result register toward the downstream side
module sbpr_out_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  sbpr_pkg::result_t res_in,
	output logic              can_take,
	output logic              out_valid,
	input  logic              out_stall,
	output sbpr_pkg::result_t res_out
);
	import sbpr_pkg::*;

	logic    valid_q;
	result_t res_q;

	assign can_take  = !valid_q || !out_stall;
	assign out_valid = valid_q;
	assign res_out   = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (can_take) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load && can_take) begin
			res_q <= res_in;
		end
	end

endmodule

[hdl/servo_bus_packet_receiver_unit.sv]
`timescale 1ns / 1ps
// top level of the servo bus packet receiver
// Parses framed packets (FF FF FD 00, id, length, instruction, error, parameters,
// crc) from a half-duplex servo bus, swallowing the host's own echo. A request
// sits in the input register and is then parsed by the byte logic into the
// result register. A new request can be taken in every cycle unless the input
// stalls, which it does only while the result register is full and stalled
// downstream. Parameter bytes come out as they arrive; the second crc
// byte gives a summary with last set and crc_ok from a crc-16 (poly 8005,
// init 0) over the header through the last parameter byte.
module servo_bus_packet_receiver_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        command,
	input  logic [7:0]  byte_value,
	input  logic [15:0] sent_count,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        kind,
	output logic [7:0]  param_byte,
	output logic [15:0] param_position,
	output logic [7:0]  packet_id,
	output logic [7:0]  instruction_code,
	output logic [7:0]  error_code,
	output logic        crc_ok,
	output logic        last
);
	import sbpr_pkg::*;

	item_t   in_item;
	item_t   item;
	logic    item_valid;
	logic    advance;
	logic    can_take;
	logic    res_valid;
	result_t res;
	result_t res_out;

	assign in_item.command    = command;
	assign in_item.byte_value = byte_value;
	assign in_item.sent_count = sent_count;

	assign advance = item_valid && can_take;

	sbpr_in_stage u_in (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_item    (in_item),
		.advance    (advance),
		.item_valid (item_valid),
		.item       (item)
	);

	sbpr_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (advance),
		.item      (item),
		.res_valid (res_valid),
		.res       (res)
	);

	sbpr_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance && res_valid),
		.res_in    (res),
		.can_take  (can_take),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.res_out   (res_out)
	);

	assign kind             = res_out.kind;
	assign param_byte       = res_out.param_byte;
	assign param_position   = res_out.param_position;
	assign packet_id        = res_out.packet_id;
	assign instruction_code = res_out.instruction_code;
	assign error_code       = res_out.error_code;
	assign crc_ok           = res_out.crc_ok;
	assign last             = res_out.last;

endmodule
